>>> hw/rtl/fault_code_status_table_top_assert.svh
// Assertion macros for the fault code status table RTL.
`ifndef FAULT_CODE_STATUS_TABLE_TOP_ASSERT_SVH
`define FAULT_CODE_STATUS_TABLE_TOP_ASSERT_SVH

// Same-cycle implication check.
`define FCST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fcst: same-cycle check failed");

// Next-cycle implication check.
`define FCST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fcst: next-cycle check failed");

`endif

>>> hw/rtl/fcst_pkg.sv
// Package with shared types, constants and helpers of the fault code status table.
`default_nettype none
package fcst_pkg;

    localparam int FCST_ENTRIES = 32;

    localparam logic [3:0] FCST_CMD_SET    = 4'd0;
    localparam logic [3:0] FCST_CMD_CLR    = 4'd1;
    localparam logic [3:0] FCST_CMD_RDST   = 4'd2;
    localparam logic [3:0] FCST_CMD_LIST   = 4'd3;
    localparam logic [3:0] FCST_CMD_COUNT  = 4'd4;
    localparam logic [3:0] FCST_CMD_CLRGRP = 4'd5;
    localparam logic [3:0] FCST_CMD_WRSNAP = 4'd6;
    localparam logic [3:0] FCST_CMD_WREXT  = 4'd7;
    localparam logic [3:0] FCST_CMD_RDSNAP = 4'd8;
    localparam logic [3:0] FCST_CMD_RDEXT  = 4'd9;

    localparam logic [23:0] FCST_CLEAR_ALL = 24'hFFFFFF;
    localparam logic [3:0]  FCST_REC_MAX   = 4'd8;
    localparam logic [5:0]  FCST_LIST_MAX  = 6'd32;
    localparam logic [5:0]  FCST_CNT_SAT   = 6'd63;

    // Slot metadata word: code, status, snapshot length, extended length
    localparam int FCST_META_W = 40;

    typedef struct packed {
        logic [7:0]  status;
        logic [23:0] found_code;
        logic        item_valid;
        logic [5:0]  match_count;
        logic [63:0] out_data;
        logic [3:0]  out_len;
        logic        ok;
        logic        last;
    } t_res;

    // Keep the low len bytes of a record word
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/fault_code_status_table_top.sv
// Fault code status table: top level with scan sequencer and result register.
// Usage:
//   Input channel (i_valid / o_stall) carries one command transaction with its
//   code, mask, group, list limit and record data. Output channel (o_valid /
//   i_stall) returns result transactions; o_last marks the final one.
//   Every command except a rejected one scans the ENTRIES slots through the
//   metadata RAM, one slot per cycle on its single read port while no list
//   scan pauses; a list scan stops at the slot that reaches its limit.
//   A rejected command goes straight to the result register. List, count and
//   clear group load their result when the scan ends; set, clear, status
//   read and record write then act on the hit or free slot, and a record
//   read of a stored record then also reads the snapshot or extended RAM.
//   A list command returns one result per listed code as the scan finds it;
//   the last one follows the scan or the limit. o_stall is high from
//   acceptance until the final result is loaded into the output register,
//   so the next command may enter while that result still waits to be taken.
//   When i_stall is high the output register holds; a list scan pauses on
//   the next match until the register frees up. Reset empties all slots at
//   once through per-slot occupancy flops. Record bytes past a length read as 0.
`default_nettype none
module fault_code_status_table_top
    import fcst_pkg::*;
#(
    parameter int ENTRIES = FCST_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_cmd,
    input  wire logic [23:0] i_fault_code,
    input  wire logic [7:0]  i_status_mask,
    input  wire logic [23:0] i_group_select,
    input  wire logic [5:0]  i_list_limit,
    input  wire logic [63:0] i_data_in,
    input  wire logic [3:0]  i_data_len,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_status,
    output logic [23:0]      o_found_code,
    output logic             o_item_valid,
    output logic [5:0]       o_match_count,
    output logic [63:0]      o_out_data,
    output logic [3:0]       o_out_len,
    output logic             o_ok,
    output logic             o_last
);

`include "fault_code_status_table_top_assert.svh"

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = IW + 1;
    localparam logic [AW-1:0] N_A    = AW'(ENTRIES);
    localparam logic [IW-1:0] LAST_I = IW'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_RDREC = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Control registers
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_dv, n_dv;
    logic [IW-1:0]      r_didx, n_didx;
    logic [ENTRIES-1:0] r_vld, n_vld;
    logic               r_hit, n_hit;
    logic               r_fv, n_fv;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_pv, n_pv;
    logic               r_ov, n_ov;

    // Payload registers
    logic [3:0]  r_cmd, n_cmd;
    logic [23:0] r_code, n_code;
    logic [7:0]  r_mask, n_mask;
    logic [23:0] r_grp, n_grp;
    logic [5:0]  r_lim, n_lim;
    logic [63:0] r_data, n_data;
    logic [3:0]  r_len, n_len;
    logic [IW-1:0] r_hidx, n_hidx;
    logic [IW-1:0] r_fidx, n_fidx;
    logic [FCST_META_W-1:0] r_hmeta, n_hmeta;
    t_res        r_pend, n_pend;
    t_res        r_res, n_res;
    t_res        r_out, n_out;

    // RAM ports
    logic                   m_we, m_re, rec_re, snap_we, ext_we;
    logic [IW-1:0]          m_waddr, rec_addr;
    logic [FCST_META_W-1:0] m_wdata, m_rdata;
    logic [63:0]            rec_wdata, snap_rdata, ext_rdata;

    // Scan evaluation
    logic        out_free, e_vld, e_match, list_take, retry, consumed, e_end, grp_hit;
    logic        is_lookup, bad;
    logic [23:0] e_code;
    logic [7:0]  e_st;
    logic [5:0]  cnt_inc;
    logic [IW-1:0] slot;
    logic        have;
    logic [7:0]  nst;
    logic [3:0]  rl;
    t_res        new_pend;

    fcst_ram #(.WIDTH(FCST_META_W), .DEPTH(ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_re(m_re), .i_raddr(r_addr[IW-1:0]), .o_rdata(m_rdata)
    );

    fcst_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_snap (
        .i_clk(i_clk), .i_we(snap_we), .i_waddr(slot), .i_wdata(rec_wdata),
        .i_re(rec_re), .i_raddr(rec_addr), .o_rdata(snap_rdata)
    );

    fcst_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_ext (
        .i_clk(i_clk), .i_we(ext_we), .i_waddr(slot), .i_wdata(rec_wdata),
        .i_re(rec_re), .i_raddr(rec_addr), .o_rdata(ext_rdata)
    );

    // Decode the slot just read and the scan decisions
    always_comb begin
        out_free  = !r_ov || !i_stall;
        e_vld     = r_vld[r_didx];
        e_code    = m_rdata[39:16];
        e_st      = m_rdata[15:8];
        e_match   = e_vld && ((e_st & r_mask) != 8'd0);
        list_take = (r_state == S_SCAN) && r_dv && (r_cmd == FCST_CMD_LIST) && e_match
                    && (r_cnt < r_lim);
        retry     = list_take && r_pv && !out_free;
        consumed  = (r_state == S_SCAN) && r_dv && !retry;
        cnt_inc   = r_cnt + 6'd1;
        e_end     = consumed && ((r_didx == LAST_I) || (list_take && (cnt_inc == r_lim)));
        grp_hit   = (r_grp == FCST_CLEAR_ALL) || (e_code[23:20] == r_grp[3:0]);
        m_re      = (r_state == S_SCAN) && (r_addr < N_A) && !retry;
        is_lookup = (r_cmd == FCST_CMD_SET) || (r_cmd == FCST_CMD_CLR)
                    || (r_cmd == FCST_CMD_RDST) || (r_cmd == FCST_CMD_WRSNAP)
                    || (r_cmd == FCST_CMD_WREXT) || (r_cmd == FCST_CMD_RDSNAP)
                    || (r_cmd == FCST_CMD_RDEXT);
        new_pend             = '0;
        new_pend.status      = e_st;
        new_pend.found_code  = e_code;
        new_pend.item_valid  = 1'b1;
        new_pend.match_count = cnt_inc;
        new_pend.ok          = 1'b1;
        slot      = r_hit ? r_hidx : r_fidx;
        have      = r_hit || r_fv;
        rl        = (r_cmd == FCST_CMD_RDSNAP) ? r_hmeta[7:4] : r_hmeta[3:0];
        rec_addr  = r_hidx;
        rec_wdata = r_data & byte_mask(r_len);
        m_waddr   = slot;
    end

    // Reject checks at acceptance
    always_comb begin
        case (i_cmd)
            FCST_CMD_SET, FCST_CMD_CLR, FCST_CMD_RDST,
            FCST_CMD_RDSNAP, FCST_CMD_RDEXT: bad = (i_fault_code == 24'd0);
            FCST_CMD_WRSNAP, FCST_CMD_WREXT: bad = (i_fault_code == 24'd0)
                || (i_data_len == 4'd0) || (i_data_len > FCST_REC_MAX);
            FCST_CMD_LIST, FCST_CMD_COUNT, FCST_CMD_CLRGRP: bad = 1'b0;
            default: bad = 1'b1;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_dv    = 1'b0;
        n_didx  = r_didx;
        n_vld   = r_vld;
        n_hit   = r_hit;
        n_fv    = r_fv;
        n_cnt   = r_cnt;
        n_pv    = r_pv;
        n_ov    = r_ov;
        n_cmd   = r_cmd;
        n_code  = r_code;
        n_mask  = r_mask;
        n_grp   = r_grp;
        n_lim   = r_lim;
        n_data  = r_data;
        n_len   = r_len;
        n_hidx  = r_hidx;
        n_fidx  = r_fidx;
        n_hmeta = r_hmeta;
        n_pend  = r_pend;
        n_res   = r_res;
        n_out   = r_out;
        m_we    = 1'b0;
        m_wdata = r_hmeta;
        rec_re  = 1'b0;
        snap_we = 1'b0;
        ext_we  = 1'b0;
        nst     = 8'd0;

        // Drain the output register
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_code  = i_fault_code;
                    n_mask  = i_status_mask;
                    n_grp   = i_group_select;
                    n_lim   = (i_list_limit > FCST_LIST_MAX) ? FCST_LIST_MAX : i_list_limit;
                    n_data  = i_data_in;
                    n_len   = i_data_len;
                    n_addr  = '0;
                    n_hit   = 1'b0;
                    n_fv    = 1'b0;
                    n_cnt   = '0;
                    n_pv    = 1'b0;
                    n_res   = '0;
                    n_res.last = 1'b1;
                    n_state = bad ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue the next slot read, or re-read after a pause
                if (retry) begin
                    n_addr = {1'b0, r_didx};
                end else if (m_re) begin
                    n_addr = r_addr + AW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_addr[IW-1:0];
                end
                if (consumed) begin
                    case (r_cmd)
                        FCST_CMD_LIST: begin
                            if (list_take) begin
                                if (r_pv) begin
                                    n_ov  = 1'b1;
                                    n_out = r_pend;
                                end
                                n_pend = new_pend;
                                n_pv   = 1'b1;
                                n_cnt  = cnt_inc;
                            end
                        end
                        FCST_CMD_COUNT: begin
                            if (e_match && (r_cnt != FCST_CNT_SAT)) begin
                                n_cnt = cnt_inc;
                            end
                        end
                        FCST_CMD_CLRGRP: begin
                            if (e_vld && grp_hit) begin
                                n_vld[r_didx] = 1'b0;
                            end
                        end
                        default: begin
                            if (e_vld && (e_code == r_code) && !r_hit) begin
                                n_hit   = 1'b1;
                                n_hidx  = r_didx;
                                n_hmeta = m_rdata;
                            end
                            if (!e_vld && !r_fv) begin
                                n_fv   = 1'b1;
                                n_fidx = r_didx;
                            end
                        end
                    endcase
                end
                // Close the scan
                if (e_end) begin
                    n_dv = 1'b0;
                    n_state = S_EMIT;
                    case (r_cmd)
                        FCST_CMD_LIST: begin
                            n_res.ok = 1'b1;
                            if (list_take) begin
                                n_res      = new_pend;
                                n_res.last = 1'b1;
                            end else if (r_pv) begin
                                n_res      = r_pend;
                                n_res.last = 1'b1;
                            end
                        end
                        FCST_CMD_COUNT: begin
                            n_res.ok          = 1'b1;
                            n_res.match_count = n_cnt;
                        end
                        FCST_CMD_CLRGRP: begin
                            n_res.ok = 1'b1;
                        end
                        default: begin
                            n_state = is_lookup ? S_DONE : S_EMIT;
                        end
                    endcase
                end
            end
            S_DONE: begin
                n_state = S_EMIT;
                case (r_cmd)
                    FCST_CMD_SET: begin
                        if (have) begin
                            nst          = (r_hit ? r_hmeta[15:8] : 8'd0) | r_mask;
                            m_we         = 1'b1;
                            m_wdata      = {r_code, nst, r_hit ? r_hmeta[7:0] : 8'd0};
                            n_vld[slot]  = 1'b1;
                            n_res.status = nst;
                            n_res.ok     = 1'b1;
                        end
                    end
                    FCST_CMD_CLR: begin
                        if (r_hit) begin
                            nst          = r_hmeta[15:8] & ~r_mask;
                            m_we         = 1'b1;
                            m_wdata      = {r_code, nst, r_hmeta[7:0]};
                            n_res.status = nst;
                            n_res.ok     = 1'b1;
                        end
                    end
                    FCST_CMD_RDST: begin
                        if (r_hit) begin
                            n_res.status = r_hmeta[15:8];
                            n_res.ok     = 1'b1;
                        end
                    end
                    FCST_CMD_WRSNAP, FCST_CMD_WREXT: begin
                        if (have) begin
                            nst = r_hit ? r_hmeta[15:8] : 8'd0;
                            m_we = 1'b1;
                            if (r_cmd == FCST_CMD_WRSNAP) begin
                                m_wdata = {r_code, nst, r_len, r_hit ? r_hmeta[3:0] : 4'd0};
                                snap_we = 1'b1;
                            end else begin
                                m_wdata = {r_code, nst, r_hit ? r_hmeta[7:4] : 4'd0, r_len};
                                ext_we  = 1'b1;
                            end
                            n_vld[slot]  = 1'b1;
                            n_res.status = nst;
                            n_res.ok     = 1'b1;
                        end
                    end
                    FCST_CMD_RDSNAP, FCST_CMD_RDEXT: begin
                        if (r_hit) begin
                            n_res.status = r_hmeta[15:8];
                            if (rl != 4'd0) begin
                                rec_re        = 1'b1;
                                n_res.out_len = rl;
                                n_res.ok      = 1'b1;
                                n_state       = S_RDREC;
                            end
                        end
                    end
                    default: begin
                        n_res.ok = 1'b0;
                    end
                endcase
            end
            S_RDREC: begin
                n_res.out_data = ((r_cmd == FCST_CMD_RDSNAP) ? snap_rdata : ext_rdata)
                                 & byte_mask(r_res.out_len);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Load the final result once the output register frees up
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_dv    <= 1'b0;
            r_didx  <= '0;
            r_vld   <= '0;
            r_hit   <= 1'b0;
            r_fv    <= 1'b0;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= n_dv;
            r_didx  <= n_didx;
            r_vld   <= n_vld;
            r_hit   <= n_hit;
            r_fv    <= n_fv;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_code  <= n_code;
        r_mask  <= n_mask;
        r_grp   <= n_grp;
        r_lim   <= n_lim;
        r_data  <= n_data;
        r_len   <= n_len;
        r_hidx  <= n_hidx;
        r_fidx  <= n_fidx;
        r_hmeta <= n_hmeta;
        r_pend  <= n_pend;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_out.status;
    assign o_found_code  = r_out.found_code;
    assign o_item_valid  = r_out.item_valid;
    assign o_match_count = r_out.match_count;
    assign o_out_data    = r_out.out_data;
    assign o_out_len     = r_out.out_len;
    assign o_ok          = r_out.ok;
    assign o_last        = r_out.last;

    `FCST_ASSERT_IMP(a_idle_no_read, i_clk, i_rst_n, r_state == S_IDLE, !r_dv)
    `FCST_ASSERT_IMP(a_item_ok, i_clk, i_rst_n, o_valid && o_item_valid, o_ok && (o_match_count != 6'd0))
    `FCST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, r_state != S_IDLE)
    `FCST_ASSERT_IMP(a_list_limit, i_clk, i_rst_n, (r_state == S_SCAN) && (r_cmd == FCST_CMD_LIST), r_cnt <= r_lim)

endmodule
`default_nettype wire
